// ----- hw/rtl/ternary_weight_row_packer_assert.svh -----
// Assertion helpers shared by the packer's modules.
`ifndef TERNARY_WEIGHT_ROW_PACKER_ASSERT_SVH
`define TERNARY_WEIGHT_ROW_PACKER_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define TRWP_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define TRWP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ----- hw/rtl/trwp_pkg.sv -----
package trwp_pkg;

   localparam int GROUP_SIZE_DEF  = 256;
   localparam int MAX_GROUPS_DEF  = 16;

   localparam int FORMAT_W        = 3;
   localparam int GROUPS_W        = 5;
   localparam int WEIGHT_W        = 8;
   localparam int SCALE_W         = 32;
   localparam int BYTE_OFFSET_W   = 13;
   localparam int CSR_IDX_W       = 2;
   localparam int CSR_DATA_W      = 8;

   localparam int QUEUE_DEPTH     = 4;
   localparam int DIGITS_PER_BYTE = 5;

   // Round-half-away division by nine on magnitudes up to 132: (m * 57) >> 9.
   localparam int RECIP9          = 57;
   localparam int RECIP9_SHIFT    = 9;
   localparam int QUOT9_W         = 4;

   typedef enum logic [FORMAT_W-1:0] {
      FMT_INT8      = 3'd0,
      FMT_TWO_BIT   = 3'd1,
      FMT_BASE3     = 3'd2,
      FMT_NIBBLE    = 3'd3,
      FMT_PLANES    = 3'd4,
      FMT_MASK_SIGN = 3'd5
   } fmt_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FORMAT_MODE = 2'd0,
      CSR_ROW_GROUPS  = 2'd1
   } csr_idx_type;

   typedef enum logic {
      REQ_WEIGHT = 1'b0,
      REQ_SCALE  = 1'b1
   } req_kind_type;

   // One queued job for the back end: one, two or four bytes.
   typedef struct packed {
      logic [1:0]               last_idx;
      logic                     pair;
      logic                     row_end;
      logic [BYTE_OFFSET_W-1:0] off_a;
      logic [BYTE_OFFSET_W-1:0] off_b;
      logic [SCALE_W-1:0]       data;
   } trwp_rec_type;

   typedef struct packed {
      logic full;
      logic empty;
   } trwp_qstat_type;

   function automatic logic [7:0] pow3(input logic [2:0] digit);
      logic [7:0] result;
      unique case (digit)
         3'd0:    result = 8'd1;
         3'd1:    result = 8'd3;
         3'd2:    result = 8'd9;
         3'd3:    result = 8'd27;
         default: result = 8'd81;
      endcase
      return result;
   endfunction

endpackage

// ----- hw/rtl/trwp_channels.sv -----
interface trwp_req_if;
   import trwp_pkg::*;
   logic                       valid;
   logic                       ready;
   logic                       req_type;
   logic signed [WEIGHT_W-1:0] weight;
   logic [SCALE_W-1:0]         scale_bits;
   modport source (output valid, req_type, weight, scale_bits, input ready);
   modport sink   (input valid, req_type, weight, scale_bits, output ready);
endinterface

interface trwp_rsp_if;
   import trwp_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [BYTE_OFFSET_W-1:0] byte_offset;
   logic [7:0]               byte_value;
   logic                     run_last;
   logic                     row_end;
   modport source (output valid, byte_offset, byte_value, run_last, row_end, input ready);
   modport sink   (input valid, byte_offset, byte_value, run_last, row_end, output ready);
endinterface

interface trwp_csr_if;
   import trwp_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/trwp_front.sv -----
`include "ternary_weight_row_packer_assert.svh"

module trwp_front #(
   parameter int GROUP_SIZE = trwp_pkg::GROUP_SIZE_DEF,
   parameter int MAX_GROUPS = trwp_pkg::MAX_GROUPS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   trwp_req_if.sink                 req_chan,
   trwp_csr_if.sink                 csr_chan,
   input  trwp_pkg::trwp_qstat_type q_stat,
   output logic                     push,
   output trwp_pkg::trwp_rec_type   push_rec
);
   import trwp_pkg::*;

   localparam int NCOLS_MAX = GROUP_SIZE * MAX_GROUPS;
   localparam int COL_W     = $clog2(NCOLS_MAX + 1);
   localparam int GCOL_W    = $clog2(GROUP_SIZE);
   localparam int NG_W      = $clog2(MAX_GROUPS + 1);
   localparam int B3_BYTES  = (GROUP_SIZE + DIGITS_PER_BYTE - 1) / DIGITS_PER_BYTE;
   localparam int OFF_W     = (COL_W + 3 > BYTE_OFFSET_W) ? COL_W + 3 : BYTE_OFFSET_W;

   fmt_type             fmt_ff, fmt_in;
   logic [GROUPS_W-1:0] groups_ff, groups_in;
   logic [COL_W-1:0]    col_ff, col_in;
   logic [GCOL_W-1:0]   gcol_ff, gcol_in;
   logic [NG_W-1:0]     scl_ff, scl_in;
   logic [7:0]          pack_ff, pack_in;
   logic [7:0]          plane_ff, plane_in;
   logic [2:0]          dplace_ff, dplace_in;
   logic [OFF_W-1:0]    b3off_ff, b3off_in;

   logic [NG_W-1:0]  ng;
   logic [COL_W-1:0] ncols;
   logic [OFF_W-1:0] ncols_w, quarter, half, eighth, payload, scale_base, col_w;
   logic [OFF_W-1:0] off_q, off_h, off_e, off_lo, off_sign;
   logic             accept, csr_wr, in_row, col_last, grp_end, scale_final, clr;
   logic             emit;
   logic signed [WEIGHT_W-1:0] w;
   logic [1:0]       code2, hi_code;
   logic [3:0]       code4, h4, lo_code;
   logic [7:0]       digit_sum;
   logic [8:0]       mag;
   logic [14:0]      mag_prod;
   logic [QUOT9_W-1:0] hq;
   trwp_rec_type     rec;

   assign req_chan.ready = !q_stat.full;
   assign csr_chan.ready = 1'b1;
   assign accept = req_chan.valid && req_chan.ready;
   assign csr_wr = csr_chan.valid && csr_chan.ready;

   // Effective group count: zero acts as one, large values saturate.
   always_comb begin
      if (groups_ff == '0) begin
         ng = NG_W'(1);
      end else if (int'(groups_ff) > MAX_GROUPS) begin
         ng = NG_W'(MAX_GROUPS);
      end else begin
         ng = NG_W'(groups_ff);
      end
   end

   assign ncols   = COL_W'(int'(ng) * GROUP_SIZE);
   assign ncols_w = OFF_W'(ncols);
   assign quarter = (ncols_w + OFF_W'(3)) >> 2;
   assign half    = (ncols_w + OFF_W'(1)) >> 1;
   assign eighth  = (ncols_w + OFF_W'(7)) >> 3;

   always_comb begin
      unique case (fmt_ff)
         FMT_INT8:      payload = ncols_w;
         FMT_TWO_BIT:   payload = quarter;
         FMT_BASE3:     payload = OFF_W'(int'(ng) * B3_BYTES);
         FMT_NIBBLE:    payload = half;
         FMT_PLANES:    payload = quarter + half;
         FMT_MASK_SIGN: payload = eighth << 1;
         default:       payload = '0;
      endcase
   end

   assign scale_base  = payload + (OFF_W'(scl_ff) << 2);
   assign scale_final = NG_W'(scl_ff + 1'b1) >= ng;
   assign col_w       = OFF_W'(col_ff);
   assign off_q       = col_w >> 2;
   assign off_h       = col_w >> 1;
   assign off_e       = col_w >> 3;
   assign off_lo      = quarter + off_h;
   assign off_sign    = eighth + off_e;
   assign in_row      = col_ff < ncols;
   assign col_last    = col_ff == ncols - COL_W'(1);
   assign grp_end     = gcol_ff == GCOL_W'(GROUP_SIZE - 1);

   // Per-format codes of the incoming weight, all wrapping as two's complement.
   assign w         = req_chan.weight;
   assign code2     = w[1:0] + 2'd1;
   assign code4     = w[3:0] + 4'd4;
   assign digit_sum = pack_ff + 8'((w[7:0] + 8'd1) * pow3(dplace_ff));
   assign mag       = w[7] ? (9'd4 - {w[7], w}) : ({w[7], w} + 9'd4);
   assign mag_prod  = 15'(mag) * 15'(RECIP9);
   assign hq        = mag_prod[RECIP9_SHIFT +: QUOT9_W];
   assign h4        = w[7] ? (4'd0 - hq[3:0]) : hq[3:0];
   assign hi_code   = h4[1:0] + 2'd1;
   assign lo_code   = w[3:0] - 4'(h4 * 4'd9) + 4'd4;

   always_comb begin
      fmt_in    = fmt_ff;
      groups_in = groups_ff;
      col_in    = col_ff;
      gcol_in   = gcol_ff;
      scl_in    = scl_ff;
      pack_in   = pack_ff;
      plane_in  = plane_ff;
      dplace_in = dplace_ff;
      b3off_in  = b3off_ff;
      emit      = 1'b0;
      clr       = 1'b0;
      rec       = '0;

      if (accept) begin
         if (req_chan.req_type == REQ_SCALE) begin
            emit         = 1'b1;
            rec.last_idx = 2'd3;
            rec.row_end  = scale_final;
            rec.off_a    = scale_base[BYTE_OFFSET_W-1:0];
            rec.data     = req_chan.scale_bits;
            scl_in       = NG_W'(scl_ff + 1'b1);
            clr          = scale_final;
         end else if (in_row) begin
            col_in  = COL_W'(col_ff + 1'b1);
            gcol_in = grp_end ? '0 : GCOL_W'(gcol_ff + 1'b1);
            unique case (fmt_ff)
               FMT_INT8: begin
                  emit          = 1'b1;
                  rec.off_a     = col_w[BYTE_OFFSET_W-1:0];
                  rec.data[7:0] = w[7:0];
               end
               FMT_TWO_BIT: begin
                  pack_in = pack_ff | (8'(code2) << {col_ff[1:0], 1'b0});
                  if (col_ff[1:0] == 2'd3 || col_last) begin
                     emit          = 1'b1;
                     rec.off_a     = off_q[BYTE_OFFSET_W-1:0];
                     rec.data[7:0] = pack_in;
                     pack_in       = '0;
                  end
               end
               FMT_BASE3: begin
                  pack_in   = digit_sum;
                  dplace_in = dplace_ff + 3'd1;
                  if (dplace_ff == 3'(DIGITS_PER_BYTE - 1) || grp_end) begin
                     emit          = 1'b1;
                     rec.off_a     = b3off_ff[BYTE_OFFSET_W-1:0];
                     rec.data[7:0] = digit_sum;
                     pack_in       = '0;
                     dplace_in     = '0;
                     b3off_in      = b3off_ff + OFF_W'(1);
                  end
               end
               FMT_NIBBLE: begin
                  pack_in = pack_ff | (8'(code4) << {col_ff[0], 2'b00});
                  if (col_ff[0] || col_last) begin
                     emit          = 1'b1;
                     rec.off_a     = off_h[BYTE_OFFSET_W-1:0];
                     rec.data[7:0] = pack_in;
                     pack_in       = '0;
                  end
               end
               FMT_PLANES: begin
                  plane_in = plane_ff | (8'(hi_code) << {col_ff[1:0], 1'b0});
                  pack_in  = pack_ff | (8'(lo_code) << {col_ff[0], 2'b00});
                  // A finished 2-bit plane byte always lands with a finished nibble byte.
                  if (col_ff[1:0] == 2'd3 || col_last) begin
                     emit           = 1'b1;
                     rec.last_idx   = 2'd1;
                     rec.pair       = 1'b1;
                     rec.off_a      = off_q[BYTE_OFFSET_W-1:0];
                     rec.off_b      = off_lo[BYTE_OFFSET_W-1:0];
                     rec.data[7:0]  = plane_in;
                     rec.data[15:8] = pack_in;
                     plane_in       = '0;
                     pack_in        = '0;
                  end else if (col_ff[0]) begin
                     emit          = 1'b1;
                     rec.off_a     = off_lo[BYTE_OFFSET_W-1:0];
                     rec.data[7:0] = pack_in;
                     pack_in       = '0;
                  end
               end
               FMT_MASK_SIGN: begin
                  pack_in  = pack_ff | (8'(w != '0) << col_ff[2:0]);
                  plane_in = plane_ff | (8'(w[7]) << col_ff[2:0]);
                  if (col_ff[2:0] == 3'd7 || col_last) begin
                     emit           = 1'b1;
                     rec.last_idx   = 2'd1;
                     rec.pair       = 1'b1;
                     rec.off_a      = off_e[BYTE_OFFSET_W-1:0];
                     rec.off_b      = off_sign[BYTE_OFFSET_W-1:0];
                     rec.data[7:0]  = pack_in;
                     rec.data[15:8] = plane_in;
                     pack_in        = '0;
                     plane_in       = '0;
                  end
               end
               default: begin
                  emit = 1'b0;
               end
            endcase
         end
      end

      if (csr_wr) begin
         if (csr_chan.index == CSR_FORMAT_MODE) begin
            fmt_in = fmt_type'(csr_chan.data[FORMAT_W-1:0]);
            clr    = 1'b1;
         end else if (csr_chan.index == CSR_ROW_GROUPS) begin
            groups_in = csr_chan.data[GROUPS_W-1:0];
            clr       = 1'b1;
         end
      end

      if (clr) begin
         col_in    = '0;
         gcol_in   = '0;
         scl_in    = '0;
         pack_in   = '0;
         plane_in  = '0;
         dplace_in = '0;
         b3off_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff    <= FMT_INT8;
         groups_ff <= GROUPS_W'(1);
         col_ff    <= '0;
         gcol_ff   <= '0;
         scl_ff    <= '0;
         pack_ff   <= '0;
         plane_ff  <= '0;
         dplace_ff <= '0;
         b3off_ff  <= '0;
      end else begin
         fmt_ff    <= fmt_in;
         groups_ff <= groups_in;
         col_ff    <= col_in;
         gcol_ff   <= gcol_in;
         scl_ff    <= scl_in;
         pack_ff   <= pack_in;
         plane_ff  <= plane_in;
         dplace_ff <= dplace_in;
         b3off_ff  <= b3off_in;
      end
   end

   assign push     = accept && emit;
   assign push_rec = rec;

   `TRWP_ASSERT_IMPLY(a_col_within_row, clock, reset, 1'b1, col_ff <= ncols)
   `TRWP_ASSERT_NEXT(a_last_scale_clears, clock, reset, accept && req_chan.req_type == REQ_SCALE && scale_final, col_ff == '0 && scl_ff == '0)

endmodule

// ----- hw/rtl/trwp_queue.sv -----
`include "ternary_weight_row_packer_assert.svh"

module trwp_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  trwp_pkg::trwp_rec_type   push_rec,
   input  logic                     pop,
   output trwp_pkg::trwp_qstat_type q_stat,
   output trwp_pkg::trwp_rec_type   head
);
   import trwp_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   trwp_rec_type     entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(wr_ff + 1'b1);
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(rd_ff + 1'b1);
      end
      cnt_in = cnt_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ff] <= push_rec;
      end
   end

   assign q_stat.full  = cnt_ff == CNT_W'(QUEUE_DEPTH);
   assign q_stat.empty = cnt_ff == '0;
   assign head         = entry_ff[rd_ff];

   `TRWP_ASSERT_IMPLY(a_no_push_when_full, clock, reset, q_stat.full, !push)
   `TRWP_ASSERT_IMPLY(a_no_pop_when_empty, clock, reset, q_stat.empty, !pop)

endmodule

// ----- hw/rtl/trwp_back.sv -----
`include "ternary_weight_row_packer_assert.svh"

module trwp_back (
   input  logic                     clock,
   input  logic                     reset,
   input  trwp_pkg::trwp_qstat_type q_stat,
   input  trwp_pkg::trwp_rec_type   head,
   output logic                     pop,
   trwp_rsp_if.source               rsp_chan
);
   import trwp_pkg::*;

   trwp_rec_type stage_ff, stage_in;
   logic         vld_ff, vld_in;
   logic [1:0]   k_ff, k_in;
   logic         take, at_last, load;

   assign at_last = k_ff == stage_ff.last_idx;
   assign take    = vld_ff && rsp_chan.ready;
   // The next job moves in as soon as the last beat of the current one leaves.
   assign load    = !q_stat.empty && (!vld_ff || (take && at_last));
   assign pop     = load;

   always_comb begin
      vld_in   = vld_ff;
      k_in     = k_ff;
      stage_in = stage_ff;
      if (load) begin
         vld_in   = 1'b1;
         k_in     = '0;
         stage_in = head;
      end else if (take) begin
         if (at_last) begin
            vld_in = 1'b0;
         end else begin
            k_in = k_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
         k_ff   <= '0;
      end else begin
         vld_ff <= vld_in;
         k_ff   <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
   end

   assign rsp_chan.valid       = vld_ff;
   assign rsp_chan.byte_offset = (stage_ff.pair && k_ff == 2'd1) ? stage_ff.off_b
                                 : stage_ff.off_a + BYTE_OFFSET_W'(k_ff);
   assign rsp_chan.byte_value  = stage_ff.data[{k_ff, 3'b000} +: 8];
   assign rsp_chan.run_last    = at_last;
   assign rsp_chan.row_end     = stage_ff.row_end && at_last;

   `TRWP_ASSERT_NEXT(a_stalled_beat_holds, clock, reset, vld_ff && !rsp_chan.ready, vld_ff && $stable(k_ff))
   `TRWP_ASSERT_IMPLY(a_beat_in_job, clock, reset, vld_ff, k_ff <= stage_ff.last_idx)

endmodule

// ----- hw/rtl/ternary_weight_row_packer.sv -----
// Ternary weight row packer: streams one matrix row of small signed weights into one of
// six byte layouts (format_mode) and appends one little-endian 32-bit scale word per
// group after the payload; every completed byte leaves as one beat with its row offset.
// A weight or scale beat is accepted every cycle while the four-entry job queue between
// the encoder and the byte serializer has room. The serializer sends one byte per cycle
// while the receiver is ready: a scale word is four bytes, a finished byte pair in the
// plane formats two, other weights one or none, so a weight stream runs at one item per
// cycle and the queue soaks up the scale bursts. A byte is registered in the queue, then
// in the serializer's stage register. Any register write restarts the row; the block does
// not hold writes off, so they belong between rows while no beat is in flight.
module ternary_weight_row_packer #(
   parameter int GROUP_SIZE = trwp_pkg::GROUP_SIZE_DEF,
   parameter int MAX_GROUPS = trwp_pkg::MAX_GROUPS_DEF
) (
   input logic        clock,
   input logic        reset,
   trwp_req_if.sink   req_chan,
   trwp_rsp_if.source rsp_chan,
   trwp_csr_if.sink   csr_chan
);
   import trwp_pkg::*;

   trwp_qstat_type q_stat;
   trwp_rec_type   push_rec;
   trwp_rec_type   head;
   logic           push;
   logic           pop;

   trwp_front #(
      .GROUP_SIZE (GROUP_SIZE),
      .MAX_GROUPS (MAX_GROUPS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .csr_chan (csr_chan),
      .q_stat   (q_stat),
      .push     (push),
      .push_rec (push_rec)
   );

   trwp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_rec (push_rec),
      .pop      (pop),
      .q_stat   (q_stat),
      .head     (head)
   );

   trwp_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_stat   (q_stat),
      .head     (head),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule

// ----- test/ternary_weight_row_packer_tb.sv -----
`timescale 1ns / 100ps

module ternary_weight_row_packer_tb;
   import trwp_pkg::*;

   localparam int COLS_PER_GROUP  = GROUP_SIZE_DEF;
   localparam int GROUP_LIMIT     = MAX_GROUPS_DEF;
   localparam int BASE3_BYTES     = (COLS_PER_GROUP + DIGITS_PER_BYTE - 1) / DIGITS_PER_BYTE;
   localparam int BYTES_PER_SCALE = 4;
   localparam logic [FORMAT_W-1:0] FMT_UNDEFINED = 3'd7;

   localparam int SETTLE_CYCLES = 8;
   localparam int END_CYCLES    = 20;
   localparam int HOLD_CYCLES   = 150;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int ROW_COLS      = 12;
   localparam int MIX_ITEMS     = 16;

   typedef struct packed {
      logic [BYTE_OFFSET_W-1:0] offset;
      logic [7:0]               value;
      logic                     last;
      logic                     row_end;
   } row_byte_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   trwp_req_if req_if();
   trwp_rsp_if rsp_if();
   trwp_csr_if csr_if();

   ternary_weight_row_packer dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   always #6 clock = ~clock;

   // Encoder state as the block should hold it.
   logic [FORMAT_W-1:0] format_reg;
   logic [GROUPS_W-1:0] groups_reg;
   int unsigned         columns_taken;
   int unsigned         scales_taken;
   int unsigned         digit_pos;
   int unsigned         digit_byte;
   logic [7:0]          main_acc;
   logic [7:0]          plane_acc;

   row_byte_type pending_bytes[$];

   int error_count   = 0;
   int items_sent    = 0;
   int cycle_count   = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_requests = 0;
   int hold_served   = 0;
   int hold_left     = 0;

   task automatic report_mismatch(input string msg);
      error_count++;
      $display("[%0t] ERROR: %s", $time, msg);
   endtask

   function automatic void clear_row_state();
      columns_taken = 0;
      scales_taken  = 0;
      digit_pos     = 0;
      digit_byte    = 0;
      main_acc      = '0;
      plane_acc     = '0;
   endfunction

   function automatic void push_byte(input int unsigned off, input logic [7:0] val,
                                     input logic rend);
      pending_bytes.push_back('{offset: BYTE_OFFSET_W'(off), value: val, last: 1'b0,
                                row_end: rend});
   endfunction

   // Works out the bytes that one accepted beat must produce.
   function automatic void encode_item(input req_kind_type kind, input logic signed [7:0] w8,
                                       input logic [SCALE_W-1:0] sbits);
      int unsigned ng, ncols, base, c, gc, grp, plane_base;
      int          w, h, r, n, place;
      logic        last_col;
      ng = groups_reg;
      if (ng == 0) ng = 1;
      if (ng > GROUP_LIMIT) ng = GROUP_LIMIT;
      ncols = ng * COLS_PER_GROUP;
      n = 0;
      if (kind == REQ_SCALE) begin
         case (format_reg)
            FMT_INT8:      base = ncols;
            FMT_TWO_BIT:   base = (ncols + 3) / 4;
            FMT_BASE3:     base = ng * BASE3_BYTES;
            FMT_NIBBLE:    base = (ncols + 1) / 2;
            FMT_PLANES:    base = (ncols + 3) / 4 + (ncols + 1) / 2;
            FMT_MASK_SIGN: base = 2 * ((ncols + 7) / 8);
            default:       base = 0;
         endcase
         base += BYTES_PER_SCALE * scales_taken;
         for (int k = 0; k < BYTES_PER_SCALE; k++) begin
            push_byte(base + k, sbits[8*k +: 8],
                      (scales_taken + 1 >= ng) && (k == BYTES_PER_SCALE - 1));
         end
         n = BYTES_PER_SCALE;
         scales_taken++;
         if (scales_taken >= ng) clear_row_state();
      end else if (columns_taken < ncols) begin
         w = w8;
         c = columns_taken;
         last_col = (c + 1 == ncols);
         case (format_reg)
            FMT_INT8: begin
               push_byte(c, w8, 1'b0);
               n++;
            end
            FMT_TWO_BIT: begin
               main_acc |= 8'(((w + 1) & 3) << (2 * (c & 3)));
               if ((c & 3) == 3 || last_col) begin
                  push_byte(c / 4, main_acc, 1'b0);
                  n++;
                  main_acc = '0;
               end
            end
            FMT_BASE3: begin
               gc = c % COLS_PER_GROUP;
               grp = c / COLS_PER_GROUP;
               place = 1;
               repeat (digit_pos % DIGITS_PER_BYTE) place *= 3;
               main_acc = 8'(main_acc + (w + 1) * place);
               digit_pos++;
               // The last byte of each group is cut short and numbering restarts.
               if (digit_pos >= DIGITS_PER_BYTE || gc == COLS_PER_GROUP - 1) begin
                  push_byte(grp * BASE3_BYTES + digit_byte, main_acc, 1'b0);
                  n++;
                  main_acc = '0;
                  digit_pos = 0;
                  digit_byte = (gc == COLS_PER_GROUP - 1) ? 0 : ((digit_byte + 1) & 8'hff);
               end
            end
            FMT_NIBBLE: begin
               main_acc |= 8'(((w + 4) & 15) << (4 * (c & 1)));
               if ((c & 1) == 1 || last_col) begin
                  push_byte(c / 2, main_acc, 1'b0);
                  n++;
                  main_acc = '0;
               end
            end
            FMT_PLANES: begin
               // Nearest multiple of nine, with halves rounded away from zero.
               h = (w >= 0) ? (w + 4) / 9 : -((4 - w) / 9);
               r = w - 9 * h;
               plane_base = (ncols + 3) / 4;
               plane_acc |= 8'(((h + 1) & 3) << (2 * (c & 3)));
               main_acc  |= 8'(((r + 4) & 15) << (4 * (c & 1)));
               if ((c & 3) == 3 || last_col) begin
                  push_byte(c / 4, plane_acc, 1'b0);
                  n++;
                  plane_acc = '0;
               end
               if ((c & 1) == 1 || last_col) begin
                  push_byte(plane_base + c / 2, main_acc, 1'b0);
                  n++;
                  main_acc = '0;
               end
            end
            FMT_MASK_SIGN: begin
               plane_base = (ncols + 7) / 8;
               if (w != 0) begin
                  main_acc |= 8'(1 << (c & 7));
                  if (w < 0) plane_acc |= 8'(1 << (c & 7));
               end
               if ((c & 7) == 7 || last_col) begin
                  push_byte(c / 8, main_acc, 1'b0);
                  push_byte(plane_base + c / 8, plane_acc, 1'b0);
                  n += 2;
                  main_acc = '0;
                  plane_acc = '0;
               end
            end
            default: begin
            end
         endcase
         columns_taken++;
      end
      if (n > 0) pending_bytes[$].last = 1'b1;
   endfunction

   function automatic logic signed [7:0] random_weight();
      case ($urandom_range(9))
         0, 1, 2, 3, 4, 5: return 8'(int'($urandom_range(2)) - 1);
         6, 7:             return 8'(int'($urandom_range(26)) - 13);
         default:          return 8'($urandom);
      endcase
   endfunction

   task automatic send_item(input req_kind_type kind, input logic signed [7:0] w8,
                            input logic [SCALE_W-1:0] sbits);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.req_type   <= kind;
      req_if.weight     <= w8;
      req_if.scale_bits <= sbits;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      encode_item(kind, w8, sbits);
      items_sent++;
   endtask

   // Drops the request valid, waits for every expected byte and lets the pipe settle.
   task automatic wait_for_idle(input int settle);
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (pending_bytes.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_register(input csr_idx_type idx, input logic [CSR_DATA_W-1:0] data);
      wait_for_idle(SETTLE_CYCLES);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= data;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      if (idx == CSR_FORMAT_MODE) begin
         format_reg = data[FORMAT_W-1:0];
      end else begin
         groups_reg = data[GROUPS_W-1:0];
      end
      clear_row_state();
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   task automatic test_directed_extremes();
      logic signed [7:0] composite [8] = '{8'sd127, -8'sd128, 8'sd13, -8'sd13,
                                           8'sd4, -8'sd5, 8'sd5, -8'sd4};
      logic signed [7:0] mask_vals [8] = '{8'sd0, 8'sd1, -8'sd1, 8'sd2,
                                           -8'sd128, 8'sd127, 8'sd0, -8'sd2};
      // Reset leaves int8 bytes and a single group.
      send_item(REQ_WEIGHT, 8'sd127, 32'h0000_0000);
      send_item(REQ_WEIGHT, -8'sd128, 32'hffff_ffff);
      send_item(REQ_WEIGHT, 8'sd0, 32'h0000_0000);
      send_item(REQ_WEIGHT, -8'sd1, 32'h0000_0000);
      send_item(REQ_SCALE, 8'sd0, 32'hffff_ffff);

      write_register(CSR_FORMAT_MODE, {5'b00000, FMT_PLANES});
      foreach (composite[i]) send_item(REQ_WEIGHT, composite[i], $urandom);
      send_item(REQ_SCALE, 8'sd0, 32'h0000_0000);

      // The half-built mask row is thrown away by the register writes below.
      write_register(CSR_FORMAT_MODE, {5'b11111, FMT_MASK_SIGN});
      foreach (mask_vals[i]) send_item(REQ_WEIGHT, mask_vals[i], $urandom);

      write_register(CSR_FORMAT_MODE, {5'b10101, FMT_UNDEFINED});
      write_register(CSR_ROW_GROUPS, 8'hff);
      send_item(REQ_WEIGHT, 8'sd1, $urandom);
      send_item(REQ_SCALE, 8'sd0, $urandom);

      // Sixteen groups of int8 put the scale words right after a 4096-byte payload.
      write_register(CSR_FORMAT_MODE, {5'b00000, FMT_INT8});
      repeat (GROUP_LIMIT) send_item(REQ_SCALE, 8'($urandom), $urandom);

      write_register(CSR_ROW_GROUPS, 8'h00);
      send_item(REQ_SCALE, 8'sd0, $urandom);
   endtask

   task automatic test_receiver_hold();
      write_register(CSR_FORMAT_MODE, {5'b00000, FMT_INT8});
      write_register(CSR_ROW_GROUPS, 8'h04);
      hold_requests++;
      repeat (40) begin
         if ($urandom_range(3) == 0) begin
            send_item(REQ_SCALE, 8'($urandom), $urandom);
         end else begin
            send_item(REQ_WEIGHT, random_weight(), $urandom);
         end
      end
   endtask

   // Starts a row in one layout and closes it early with its scale words; the last
   // scale word drops any partial bytes and restarts the row.
   task automatic test_row_start(input fmt_type fmt, input int groups_val, input int cols);
      int         early_col;
      logic [7:0] upper;
      upper = 8'($urandom);
      write_register(CSR_FORMAT_MODE, {upper[7:3], fmt});
      write_register(CSR_ROW_GROUPS, {upper[7:5], 5'(groups_val)});
      early_col = (groups_val > 1) ? int'($urandom_range(cols - 1)) : cols;
      for (int c = 0; c < cols; c++) begin
         if (c == early_col) send_item(REQ_SCALE, 8'($urandom), $urandom);
         send_item(REQ_WEIGHT, random_weight(), $urandom);
      end
      repeat (groups_val - ((early_col < cols) ? 1 : 0)) begin
         send_item(REQ_SCALE, 8'($urandom), $urandom);
      end
   endtask

   task automatic test_random_mix(input int count);
      int         first;
      logic [7:0] data;
      first = items_sent;
      while (items_sent - first < count) begin
         case ($urandom_range(19))
            0: write_register(CSR_FORMAT_MODE, 8'($urandom));
            1: begin
               data = 8'($urandom);
               case ($urandom_range(5))
                  0:       data[4:0] = 5'd0;
                  1:       data[4:0] = 5'(GROUP_LIMIT);
                  2:       data[4:0] = 5'($urandom_range(GROUP_LIMIT + 1, 31));
                  default: data[4:0] = 5'($urandom_range(1, 3));
               endcase
               write_register(CSR_ROW_GROUPS, data);
            end
            2, 3, 4: send_item(REQ_SCALE, 8'($urandom), $urandom);
            default: send_item(REQ_WEIGHT, random_weight(), $urandom);
         endcase
      end
   endtask

   // Result side: random back-pressure, plus a long hold whenever a test asks for one.
   always @(negedge clock) begin
      if (hold_requests != hold_served) begin
         hold_served = hold_requests;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin : check_bytes
      row_byte_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_bytes.size() == 0) begin
            report_mismatch($sformatf("unexpected beat: offset %0d value 0x%02h",
                                      rsp_if.byte_offset, rsp_if.byte_value));
         end else begin
            want = pending_bytes.pop_front();
            if (rsp_if.byte_offset !== want.offset)
               report_mismatch($sformatf("byte_offset %0d, expected %0d",
                                         rsp_if.byte_offset, want.offset));
            if (rsp_if.byte_value !== want.value)
               report_mismatch($sformatf("byte_value 0x%02h, expected 0x%02h at offset %0d",
                                         rsp_if.byte_value, want.value, want.offset));
            if (rsp_if.run_last !== want.last)
               report_mismatch($sformatf("run_last %b, expected %b at offset %0d",
                                         rsp_if.run_last, want.last, want.offset));
            if (rsp_if.row_end !== want.row_end)
               report_mismatch($sformatf("row_end %b, expected %b at offset %0d",
                                         rsp_if.row_end, want.row_end, want.offset));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("ternary_weight_row_packer: mismatch");
         $finish;
      end
   end

   initial begin
      req_if.valid      = 1'b0;
      req_if.req_type   = REQ_WEIGHT;
      req_if.weight     = '0;
      req_if.scale_bits = '0;
      rsp_if.ready      = 1'b0;
      csr_if.valid      = 1'b0;
      csr_if.index      = CSR_FORMAT_MODE;
      csr_if.data       = '0;
      format_reg        = FMT_INT8;
      groups_reg        = 5'd1;
      clear_row_state();

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 23;
      recv_idle_pct = 46;
      test_directed_extremes();
      test_row_start(FMT_INT8, 1, ROW_COLS);
      test_row_start(FMT_BASE3, 2, ROW_COLS);
      test_random_mix(MIX_ITEMS);

      send_idle_pct = 46;
      recv_idle_pct = 23;
      test_row_start(FMT_TWO_BIT, 1, ROW_COLS);
      test_row_start(FMT_PLANES, 1, ROW_COLS);
      test_random_mix(MIX_ITEMS);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_receiver_hold();
      test_row_start(FMT_NIBBLE, 1, ROW_COLS);
      test_row_start(FMT_MASK_SIGN, 1, ROW_COLS);
      test_random_mix(MIX_ITEMS);

      wait_for_idle(END_CYCLES);
      if (error_count == 0) begin
         $display("ternary_weight_row_packer: match");
      end else begin
         $display("ternary_weight_row_packer: mismatch");
      end
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/trwp_pkg.sv
hw/rtl/trwp_channels.sv
hw/rtl/trwp_front.sv
hw/rtl/trwp_queue.sv
hw/rtl/trwp_back.sv
hw/rtl/ternary_weight_row_packer.sv
test/ternary_weight_row_packer_tb.sv
